// ===== design/assert_macros.svh =====
// Assertion macros used by the parser top level.
// Clocked on clk_i, disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an expression holds at every clock edge.
`define FFHP_ASSERT(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// Check that a consequent holds in the cycle after its antecedent.
`define FFHP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/ffhp_pkg.sv =====
// Types, codes and decode tables for the FLAC frame header parser.
// No dependencies; used by all parser modules and the top level.
package ffhp_pkg;

  localparam logic [7:0]  SyncByte     = 8'hFF;
  localparam logic [7:0]  Sync2Mask    = 8'hFC;
  localparam logic [7:0]  Sync2Value   = 8'hF8;
  localparam logic [7:0]  CrcPoly      = 8'h07;
  localparam int unsigned IndexMsb     = 31;
  localparam logic [3:0]  ChanMaxCode  = 4'd10;

  typedef enum logic [3:0] {
    ST_OK        = 4'd0,
    ST_SYNC      = 4'd1,
    ST_RESERVED  = 4'd2,
    ST_CHANNEL   = 4'd3,
    ST_DEPTH     = 4'd4,
    ST_CODED_NUM = 4'd5,
    ST_INDEX_BIG = 4'd6,
    ST_BLOCKSIZE = 4'd7,
    ST_RATE      = 4'd8,
    ST_CRC       = 4'd9
  } ffhp_status_e;

  typedef enum logic [8:0] {
    PH_IDLE    = 9'b000000001,
    PH_SYNC2   = 9'b000000010,
    PH_CODES   = 9'b000000100,
    PH_CHDEPTH = 9'b000001000,
    PH_NUMHEAD = 9'b000010000,
    PH_NUMCONT = 9'b000100000,
    PH_BLKEXT  = 9'b001000000,
    PH_RATEEXT = 9'b010000000,
    PH_CRC     = 9'b100000000
  } ffhp_phase_e;

  typedef struct packed {
    logic [7:0] header_byte;
    logic       start_of_header;
  } ffhp_item_t;

  typedef struct packed {
    ffhp_status_e status;
    logic         strategy_flag;
    logic [3:0]   channel_assignment;
    logic [3:0]   channel_count;
    logic [5:0]   sample_bits;
    logic [16:0]  samples_per_block;
    logic [19:0]  rate_hz;
    logic [35:0]  position;
  } ffhp_result_t;

  function automatic logic [7:0] crc8_byte(logic [7:0] crc, logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ CrcPoly) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

  function automatic logic [3:0] leading_ones(logic [7:0] b);
    logic [3:0] n;
    logic       run;
    n   = 4'd0;
    run = 1'b1;
    for (int i = 7; i >= 0; i--) begin
      run = run & b[i];
      if (run) n = n + 4'd1;
    end
    return n;
  endfunction

  function automatic logic [16:0] block_len_lut(logic [3:0] code);
    logic [16:0] s;
    s = '0;
    if (code == 4'd1) begin
      s = 17'd192;
    end else if (code >= 4'd2 && code <= 4'd5) begin
      s = 17'd576 << (code - 4'd2);
    end else if (code >= 4'd8) begin
      s = 17'd256 << (code - 4'd8);
    end
    return s;
  endfunction

  function automatic logic [19:0] rate_table(logic [3:0] code);
    logic [19:0] r;
    unique case (code)
      4'd1:    r = 20'd88200;
      4'd2:    r = 20'd176400;
      4'd3:    r = 20'd192000;
      4'd4:    r = 20'd8000;
      4'd5:    r = 20'd16000;
      4'd6:    r = 20'd22050;
      4'd7:    r = 20'd24000;
      4'd8:    r = 20'd32000;
      4'd9:    r = 20'd44100;
      4'd10:   r = 20'd48000;
      4'd11:   r = 20'd96000;
      default: r = 20'd0;
    endcase
    return r;
  endfunction

  function automatic logic [5:0] depth_table(logic [2:0] code);
    logic [5:0] d;
    unique case (code)
      3'd1:    d = 6'd8;
      3'd2:    d = 6'd12;
      3'd4:    d = 6'd16;
      3'd5:    d = 6'd20;
      3'd6:    d = 6'd24;
      default: d = 6'd0;
    endcase
    return d;
  endfunction

endpackage

// ===== design/ffhp_byte_if.sv =====
// Header byte channel: valid/ready handshake with byte and restart flag.
// Depends on nothing.
interface ffhp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] header_byte;
  logic       start_of_header;

  modport source (output valid, output header_byte, output start_of_header, input ready);
  modport sink   (input valid, input header_byte, input start_of_header, output ready);
endinterface

// ===== design/ffhp_result_if.sv =====
// Parse result channel: valid/ready handshake with the decoded header fields.
// Depends on nothing.
interface ffhp_result_if;
  logic        valid;
  logic        ready;
  logic [3:0]  status;
  logic        strategy_flag;
  logic [3:0]  channel_assignment;
  logic [3:0]  channel_count;
  logic [5:0]  sample_bits;
  logic [16:0] samples_per_block;
  logic [19:0] rate_hz;
  logic [35:0] position;

  modport source (output valid, output status, output strategy_flag,
                  output channel_assignment, output channel_count, output sample_bits,
                  output samples_per_block, output rate_hz, output position, input ready);
  modport sink   (input valid, input status, input strategy_flag,
                  input channel_assignment, input channel_count, input sample_bits,
                  input samples_per_block, input rate_hz, input position, output ready);
endinterface

// ===== design/ffhp_in_stage.sv =====
// Input register for header bytes.
// Depends on ffhp_pkg.
module ffhp_in_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  ffhp_pkg::ffhp_item_t item_i,
  input  logic                take_i,
  output logic                valid_o,
  output ffhp_pkg::ffhp_item_t item_o
);

  logic                 valid_q, valid_d;
  ffhp_pkg::ffhp_item_t item_q;

  // Free when empty or when the held byte moves on this cycle.
  assign ready_o = !valid_q || take_i;
  assign valid_d = (valid_i && ready_o) || (valid_q && !take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ===== design/ffhp_parser.sv =====
// Header state and per-byte decode: sync, codes, coded number, extensions, CRC-8.
// Depends on ffhp_pkg.
module ffhp_parser (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  ffhp_pkg::ffhp_item_t  item_i,
  output logic                  res_valid_o,
  output ffhp_pkg::ffhp_result_t res_o
);

  ffhp_pkg::ffhp_phase_e phase_q, phase_d, ph;
  logic [2:0]  cont_q, cont_d;
  logic [35:0] acc_q, acc_d;
  logic [3:0]  blk_q, blk_d;
  logic [3:0]  rate_q, rate_d;
  logic [3:0]  chan_q, chan_d;
  logic [2:0]  depth_q, depth_d;
  logic        strat_q, strat_d;
  logic [15:0] ext_q, ext_d, ext_new;
  logic [7:0]  crc_q, crc_d;
  logic [16:0] samples_q, samples_d;

  logic [7:0]  b;
  logic [3:0]  ones;
  logic        err, num_done, blk_done;
  ffhp_pkg::ffhp_status_e err_code;
  logic [19:0] rate_out;

  assign b    = item_i.header_byte;
  assign ones = ffhp_pkg::leading_ones(b);

  always_comb begin
    priority if (rate_q == 4'd12) begin
      rate_out = {12'd0, ext_q[7:0]} * 20'd1000;
    end else if (rate_q == 4'd13) begin
      rate_out = {4'd0, ext_q};
    end else if (rate_q == 4'd14) begin
      rate_out = {4'd0, ext_q} * 20'd10;
    end else begin
      rate_out = ffhp_pkg::rate_table(rate_q);
    end
  end

  always_comb begin
    ph          = item_i.start_of_header ? ffhp_pkg::PH_IDLE : phase_q;
    phase_d     = ph;
    cont_d      = cont_q;
    acc_d       = acc_q;
    blk_d       = blk_q;
    rate_d      = rate_q;
    chan_d      = chan_q;
    depth_d     = depth_q;
    strat_d     = strat_q;
    ext_d       = ext_q;
    ext_new     = {ext_q[7:0], b};
    crc_d       = crc_q;
    samples_d   = samples_q;
    err         = 1'b0;
    err_code    = ffhp_pkg::ST_OK;
    num_done    = 1'b0;
    blk_done    = 1'b0;
    res_valid_o = 1'b0;
    res_o       = '0;

    if (ph != ffhp_pkg::PH_CRC) begin
      crc_d = ffhp_pkg::crc8_byte((ph == ffhp_pkg::PH_IDLE) ? 8'h00 : crc_q, b);
    end

    unique case (ph)
      ffhp_pkg::PH_IDLE: begin
        if (b != ffhp_pkg::SyncByte) begin
          err = 1'b1; err_code = ffhp_pkg::ST_SYNC;
        end else begin
          phase_d = ffhp_pkg::PH_SYNC2;
        end
      end
      ffhp_pkg::PH_SYNC2: begin
        if ((b & ffhp_pkg::Sync2Mask) != ffhp_pkg::Sync2Value) begin
          err = 1'b1; err_code = ffhp_pkg::ST_SYNC;
        end else if (b[1]) begin
          err = 1'b1; err_code = ffhp_pkg::ST_RESERVED;
        end else begin
          strat_d = b[0];
          phase_d = ffhp_pkg::PH_CODES;
        end
      end
      ffhp_pkg::PH_CODES: begin
        blk_d   = b[7:4];
        rate_d  = b[3:0];
        phase_d = ffhp_pkg::PH_CHDEPTH;
      end
      ffhp_pkg::PH_CHDEPTH: begin
        chan_d  = b[7:4];
        depth_d = b[3:1];
        if (b[7:4] > ffhp_pkg::ChanMaxCode) begin
          err = 1'b1; err_code = ffhp_pkg::ST_CHANNEL;
        end else if (b[3:1] == 3'd3 || b[3:1] == 3'd7) begin
          err = 1'b1; err_code = ffhp_pkg::ST_DEPTH;
        end else if (b[0]) begin
          err = 1'b1; err_code = ffhp_pkg::ST_RESERVED;
        end else begin
          phase_d = ffhp_pkg::PH_NUMHEAD;
        end
      end
      ffhp_pkg::PH_NUMHEAD: begin
        if (ones == 4'd0) begin
          acc_d    = {28'd0, b};
          num_done = 1'b1;
        end else if (ones == 4'd1 || ones == 4'd8) begin
          err = 1'b1; err_code = ffhp_pkg::ST_CODED_NUM;
        end else begin
          acc_d   = {28'd0, b & (8'h7F >> ones)};
          cont_d  = ones[2:0] - 3'd1;
          phase_d = ffhp_pkg::PH_NUMCONT;
        end
      end
      ffhp_pkg::PH_NUMCONT: begin
        if (b[7:6] != 2'b10) begin
          err = 1'b1; err_code = ffhp_pkg::ST_CODED_NUM;
        end else begin
          acc_d  = {acc_q[29:0], b[5:0]};
          cont_d = cont_q - 3'd1;
          if (cont_q == 3'd1) num_done = 1'b1;
        end
      end
      ffhp_pkg::PH_BLKEXT: begin
        ext_d  = ext_new;
        cont_d = cont_q - 3'd1;
        if (cont_q == 3'd1) begin
          samples_d = {1'b0, ext_new} + 17'd1;
          blk_done  = 1'b1;
        end
      end
      ffhp_pkg::PH_RATEEXT: begin
        ext_d  = ext_new;
        cont_d = cont_q - 3'd1;
        if (cont_q == 3'd1) phase_d = ffhp_pkg::PH_CRC;
      end
      ffhp_pkg::PH_CRC: begin
        if (b != crc_q) begin
          err = 1'b1; err_code = ffhp_pkg::ST_CRC;
        end else begin
          res_valid_o              = 1'b1;
          res_o.status             = ffhp_pkg::ST_OK;
          res_o.strategy_flag      = strat_q;
          res_o.channel_assignment = chan_q;
          res_o.channel_count      = (chan_q < 4'd8) ? chan_q + 4'd1 : 4'd2;
          res_o.sample_bits        = ffhp_pkg::depth_table(depth_q);
          res_o.samples_per_block  = samples_q;
          res_o.rate_hz            = rate_out;
          res_o.position           = acc_q;
          phase_d                  = ffhp_pkg::PH_IDLE;
        end
      end
      default: begin
        phase_d = ffhp_pkg::PH_IDLE;
      end
    endcase

    // Coded number complete: range and block-code checks, then block size or its extension.
    if (num_done) begin
      if (!strat_q && acc_d[35:ffhp_pkg::IndexMsb] != '0) begin
        err = 1'b1; err_code = ffhp_pkg::ST_INDEX_BIG;
      end else if (blk_q == 4'd0) begin
        err = 1'b1; err_code = ffhp_pkg::ST_BLOCKSIZE;
      end else begin
        ext_d = '0;
        if (blk_q == 4'd6) begin
          cont_d  = 3'd1;
          phase_d = ffhp_pkg::PH_BLKEXT;
        end else if (blk_q == 4'd7) begin
          cont_d  = 3'd2;
          phase_d = ffhp_pkg::PH_BLKEXT;
        end else begin
          samples_d = ffhp_pkg::block_len_lut(blk_q);
          blk_done  = 1'b1;
        end
      end
    end

    // Block size known: rate check, then rate extension or the CRC byte.
    if (blk_done) begin
      if (rate_q == 4'd15) begin
        err = 1'b1; err_code = ffhp_pkg::ST_RATE;
      end else begin
        ext_d = '0;
        if (rate_q == 4'd12) begin
          cont_d  = 3'd1;
          phase_d = ffhp_pkg::PH_RATEEXT;
        end else if (rate_q == 4'd13 || rate_q == 4'd14) begin
          cont_d  = 3'd2;
          phase_d = ffhp_pkg::PH_RATEEXT;
        end else begin
          phase_d = ffhp_pkg::PH_CRC;
        end
      end
    end

    if (err) begin
      phase_d      = ffhp_pkg::PH_IDLE;
      res_valid_o  = 1'b1;
      res_o        = '0;
      res_o.status = err_code;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= ffhp_pkg::PH_IDLE;
      cont_q    <= '0;
      acc_q     <= '0;
      blk_q     <= '0;
      rate_q    <= '0;
      chan_q    <= '0;
      depth_q   <= '0;
      strat_q   <= 1'b0;
      ext_q     <= '0;
      crc_q     <= '0;
      samples_q <= '0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      cont_q    <= cont_d;
      acc_q     <= acc_d;
      blk_q     <= blk_d;
      rate_q    <= rate_d;
      chan_q    <= chan_d;
      depth_q   <= depth_d;
      strat_q   <= strat_d;
      ext_q     <= ext_d;
      crc_q     <= crc_d;
      samples_q <= samples_d;
    end
  end

endmodule

// ===== design/ffhp_out_stage.sv =====
// Result register in front of the result channel.
// Depends on ffhp_pkg.
module ffhp_out_stage (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   load_i,
  input  ffhp_pkg::ffhp_result_t res_i,
  output logic                   free_o,
  output logic                   valid_o,
  input  logic                   ready_i,
  output ffhp_pkg::ffhp_result_t res_o
);

  logic                   valid_q;
  ffhp_pkg::ffhp_result_t res_q;

  assign free_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

// ===== design/flac_frame_header_parser_top.sv =====
// FLAC frame header parser, top level.
// Channels: byte_i carries one header byte per transaction plus a restart
// flag (start_of_header) that abandons any header in progress; result_o
// carries one parse result per header: status and decoded fields.
// A result appears when the header ends (CRC byte) or at the first error;
// on an error all fields but status read zero. Bytes after a result start
// a new header whatever the restart flag says.
// Flow: a byte is decoded combinationally straight out of the input register,
// and its result (if any) loads into the result register at the edge where
// the byte advances; the result is then offered from that register.
// Throughput: one byte per cycle while no result waits on result_o.ready, set by the single decode stage.
// Reset: both registers empty, parser waits for the first sync byte.
// Stall: while a result waits on result_o.ready, the next byte is held in
// the input register and byte_i.ready drops once that register is full.
// Depends on ffhp_pkg, ffhp_byte_if, ffhp_result_if and assert_macros.svh.
`include "assert_macros.svh"
module flac_frame_header_parser_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  ffhp_byte_if.sink     byte_i,
  ffhp_result_if.source result_o
);

  ffhp_pkg::ffhp_item_t   in_item, item;
  ffhp_pkg::ffhp_result_t res, res_out;
  logic item_valid, out_free, step, res_valid;

  assign in_item.header_byte     = byte_i.header_byte;
  assign in_item.start_of_header = byte_i.start_of_header;

  // Advance a byte only when the result register can take what it yields.
  assign step = item_valid && out_free;

  ffhp_in_stage u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (byte_i.valid),
    .ready_o (byte_i.ready),
    .item_i  (in_item),
    .take_i  (step),
    .valid_o (item_valid),
    .item_o  (item)
  );

  ffhp_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .item_i      (item),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  ffhp_out_stage u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (step && res_valid),
    .res_i   (res),
    .free_o  (out_free),
    .valid_o (result_o.valid),
    .ready_i (result_o.ready),
    .res_o   (res_out)
  );

  assign result_o.status             = res_out.status;
  assign result_o.strategy_flag      = res_out.strategy_flag;
  assign result_o.channel_assignment = res_out.channel_assignment;
  assign result_o.channel_count      = res_out.channel_count;
  assign result_o.sample_bits        = res_out.sample_bits;
  assign result_o.samples_per_block  = res_out.samples_per_block;
  assign result_o.rate_hz            = res_out.rate_hz;
  assign result_o.position           = res_out.position;

  `FFHP_ASSERT_NEXT(a_result_registered, step && res_valid, result_o.valid,
    "decoded result not presented on the result channel")

  `FFHP_ASSERT(a_error_fields_zero,
    !(result_o.valid && result_o.status != ffhp_pkg::ST_OK) ||
    (result_o.channel_count == '0 && result_o.samples_per_block == '0 &&
     result_o.rate_hz == '0 && result_o.position == '0),
    "error result carries non-zero fields")

  `FFHP_ASSERT(a_ok_fields_sane,
    !(result_o.valid && result_o.status == ffhp_pkg::ST_OK) ||
    (result_o.channel_count != '0 && result_o.samples_per_block != '0),
    "good header result with empty channel count or block size")

endmodule
